// ----- design/int32_to_decimal_ascii_core_assert.svh -----
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_core_assert.svh
// Assertion macros used by the i2a_ctrl controller of the int32 to decimal ASCII core.
// ----------------------------------------------------------------------------
`ifndef INT32_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define INT32_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define I2A_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define I2A_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/i2a_pkg.sv -----
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types and constants for the int32 to decimal ASCII core.
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

    localparam int VALUE_W    = 32;
    localparam int MAG_W      = 32;
    localparam int CMP_W      = MAG_W + 2;
    localparam int CHAR_W     = 6;
    localparam int NUM_DIGITS = 10;
    localparam int RADIX      = 10;
    localparam int POS_W      = 4;
    localparam int DIGIT_W    = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    typedef logic [NUM_DIGITS-1:0][RADIX-1:0][CMP_W-1:0] t_mult_tab;

    // k * 10^p for every digit position p and digit k
    function automatic t_mult_tab build_mult();
        t_mult_tab   tab;
        logic [CMP_W-1:0] pw;
        pw = CMP_W'(1);
        for (int p = 0; p < NUM_DIGITS; p++) begin
            for (int k = 0; k < RADIX; k++) begin
                tab[p][k] = CMP_W'(pw * CMP_W'(k));
            end
            pw = CMP_W'(pw * CMP_W'(RADIX));
        end
        return tab;
    endfunction

    localparam t_mult_tab MULT = build_mult();

    typedef struct packed {
        logic load;
        logic find;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic last_digit;
    } t_status;

endpackage

`default_nettype wire

// ----- design/int32_to_decimal_ascii_core.sv -----
// The accepted word is loaded in ST_IDLE, its length found in ST_START, and the first
// character registered from ST_SIGN or ST_DIGITS. Throughput: one character per cycle
// while the output is ready; a value (1 to 11 characters) holds o_ready low to its end.
// Reset: synchronous, active low; clears the controller state and output valid only.
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_core
// Signed 32-bit integer to decimal ASCII text, one character word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module int32_to_decimal_ascii_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [i2a_pkg::VALUE_W-1:0]   i_value,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [i2a_pkg::CHAR_W-1:0]    o_character,
    output logic                               o_last
);
    import i2a_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    i2a_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    i2a_dp u_dp (
        .i_clk       (i_clk),
        .i_value     (i_value),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// ----- design/i2a_dp.sv -----
// ----------------------------------------------------------------------------
// i2a_dp
// Datapath: sign and magnitude, digit count, one decimal digit per word.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_dp (
    input  wire logic                          i_clk,
    input  wire logic [i2a_pkg::VALUE_W-1:0]   i_value,
    input  wire i2a_pkg::t_cmd                 i_cmd,
    output i2a_pkg::t_status                   o_status,
    output logic      [i2a_pkg::CHAR_W-1:0]    o_character,
    output logic                               o_last
);
    import i2a_pkg::*;

    logic                r_neg;
    logic [MAG_W-1:0]    r_mag;
    logic [POS_W-1:0]    r_pos;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;

    logic [CMP_W-1:0]    w_mag_ext;
    logic [POS_W-1:0]    w_len;
    logic [DIGIT_W-1:0]  w_digit;
    logic [CMP_W-1:0]    w_rem;

    assign w_mag_ext = CMP_W'(r_mag);

    // index of the most significant digit (0 for a zero magnitude)
    always_comb begin
        w_len = '0;
        for (int i = 1; i < NUM_DIGITS; i++) begin
            w_len = w_len + POS_W'(w_mag_ext >= MULT[i][1]);
        end
    end

    always_comb begin
        w_digit = '0;
        for (int k = 1; k < RADIX; k++) begin
            w_digit = w_digit + DIGIT_W'(w_mag_ext >= MULT[r_pos][k]);
        end
        w_rem = w_mag_ext - MULT[r_pos][w_digit];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[VALUE_W-1];
            r_mag <= i_value[VALUE_W-1] ? MAG_W'(-i_value) : MAG_W'(i_value);
        end else if (i_cmd.emit_digit) begin
            r_mag <= w_rem[MAG_W-1:0];
        end

        if (i_cmd.find) begin
            r_pos <= w_len;
        end else if (i_cmd.emit_digit && r_pos != '0) begin
            r_pos <= r_pos - POS_W'(1);
        end

        if (i_cmd.emit_sign) begin
            r_char <= ASCII_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= ASCII_ZERO + CHAR_W'(w_digit);
            r_last <= (r_pos == '0);
        end
    end

    assign o_status.neg        = r_neg;
    assign o_status.last_digit = (r_pos == '0);
    assign o_character         = r_char;
    assign o_last              = r_last;

endmodule

`default_nettype wire

// ----- design/i2a_ctrl.sv -----
// ----------------------------------------------------------------------------
// i2a_ctrl
// Controller: sequences load, length search, sign and digit words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "int32_to_decimal_ascii_core_assert.svh"

module i2a_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_ready,
    input  wire i2a_pkg::t_status  i_status,
    output i2a_pkg::t_cmd          o_cmd
);
    import i2a_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_START  = 2'd1;
    localparam logic [1:0] ST_SIGN   = 2'd2;
    localparam logic [1:0] ST_DIGITS = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_slot_free;
    t_cmd       w_cmd;

    assign w_slot_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = ST_START;
                end
            end
            ST_START: begin
                w_cmd.find = 1'b1;
                n_state    = i_status.neg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN: begin
                if (w_slot_free) begin
                    w_cmd.emit_sign = 1'b1;
                    n_state         = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (w_slot_free) begin
                    w_cmd.emit_digit = 1'b1;
                    if (i_status.last_digit) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.emit_sign || w_cmd.emit_digit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = w_cmd;

    `I2A_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, i_valid && o_ready,
        r_state == ST_START, "accepted word did not start conversion")
    `I2A_ASSERT_NXT(a_last_digit_done, i_clk, i_rst_n,
        w_cmd.emit_digit && i_status.last_digit,
        r_state == ST_IDLE && r_out_valid, "final digit did not end the number")
    `I2A_ASSERT_IMP(a_sign_only_neg, i_clk, i_rst_n, r_state == ST_SIGN,
        i_status.neg, "sign state entered for a non-negative value")
    `I2A_ASSERT_IMP(a_valid_from_emit, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state) == ST_SIGN || $past(r_state) == ST_DIGITS,
        "output word appeared without an emit")

endmodule

`default_nettype wire
